### sv/ipba_pkg.sv
// Shared types, codes and helpers for the IPv4 pool bitmap allocator.
package ipba_pkg;

  // Request kinds carried on in_tuser
  localparam logic OP_ALLOC   = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  // Result status codes carried on out_tuser
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_DRAINED = 2'd2;

  // Configuration register indexes
  localparam logic [0:0] CFG_POOL_NETWORK  = 1'b0;
  localparam logic [0:0] CFG_PREFIX_LENGTH = 1'b1;

  localparam logic [5:0]  MAX_PREFIX     = 6'd30;
  localparam logic [5:0]  PREFIX_RESET   = 6'd32;
  localparam int          RESERVED_COUNT = 3;
  localparam logic [63:0] WORD_ALL       = 64'hFFFF_FFFF_FFFF_FFFF;

  // Controller to datapath
  typedef struct packed {
    logic       clr_step;
    logic       ld;
    logic       gs_rd;
    logic       g_found;
    logic       w_rd;
    logic       latch;
    logic       a_wr;
    logic       r_rd;
    logic       r_wr;
    logic       g_rd;
    logic       g_set;
    logic       g_clr;
    logic       res_ld;
    logic [1:0] res_status;
    logic       res_grant;
  } ipba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clr_last;
    logic pool_ok;
    logic drained;
    logic is_release;
    logic oor;
    logic rd_full;
    logic chk_end;
    logic rel_hit;
    logic gchunk_full;
    logic gchunk_last;
    logic new_full;
    logic cur_end;
  } ipba_sts_t;

  // Lowest clear bit of a word; 63 when bits 0..62 are all set
  function automatic logic [5:0] lowest_zero(input logic [63:0] w);
    logic [5:0] b;
    b = 6'd63;
    for (int i = 62; i >= 0; i--) begin
      if (!w[i]) b = 6'(i);
    end
    return b;
  endfunction

endpackage

### sv/ipv4_pool_bitmap_allocator_unit.sv
// Top level of the IPv4 pool bitmap allocator.
// Hands out the lowest free host address of pool_network/prefix_length (entry i is
// pool_network+2+i) and takes addresses back; one result word per request word.
// After reset a clearing pass writes all 2^(POOL_BITS-6) words of the used-bit RAM
// (1024 at the default), one 64-bit word per cycle; in_tready stays low meanwhile, but
// configuration writes are taken at any time. The block works on one request at a
// time, reading the used-bit RAM at most once per cycle. An invalid pool, an
// out-of-range release or an allocate refused by the used count go from dispatch
// straight to the result; a release of a held entry also clears its used bit and its
// group's full bit. An allocate reads one group-full RAM entry per 64 groups until a
// group is not full (else it is refused), then that group's words in order until one
// has a clear bit, and sets the lowest; when the granted word fills up, the rest of
// the group is read, one word a cycle, until a word with a clear bit is found, and a
// group that becomes full gets its full bit set. The next request is taken only once
// the block is back in idle. A finished result waits in the output register while
// the next request is taken; the result after it waits in the block until that
// register frees.
module ipv4_pool_bitmap_allocator_unit #(
  parameter int POOL_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [31:0] cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] address
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] granted_address
  output logic [1:0]  out_tuser   // [1:0] status
);

  ipba_pkg::ipba_cmd_t cmd;
  ipba_pkg::ipba_sts_t sts;

  ipba_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  ipba_dpath #(
    .POOL_BITS (POOL_BITS)
  ) u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_op      (in_tuser),
    .in_addr    (in_tdata),
    .cmd        (cmd),
    .sts        (sts),
    .out_status (out_tuser),
    .out_addr   (out_tdata)
  );

endmodule

### sv/ipba_ctrl.sv
// Sequencer for the allocator: clearing pass, search, update and result hand-off.
module ipba_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  ipba_pkg::ipba_sts_t sts,
  output ipba_pkg::ipba_cmd_t cmd
);

  typedef enum logic [14:0] {
    S_CLEAR    = 15'h0001,
    S_IDLE     = 15'h0002,
    S_DISPATCH = 15'h0004,
    S_GS_CHK   = 15'h0008,
    S_WS_RD    = 15'h0010,
    S_WS_CHK   = 15'h0020,
    S_A_WR     = 15'h0040,
    S_RS_RD    = 15'h0080,
    S_RS_CHK   = 15'h0100,
    S_G_RD     = 15'h0200,
    S_G_WR     = 15'h0400,
    S_R_RD     = 15'h0800,
    S_R_CHK    = 15'h1000,
    S_R_WR     = 15'h2000,
    S_FIN      = 15'h4000
  } state_t;

  state_t     st_r, st_nxt;
  logic [1:0] status_r, status_nxt;
  logic       grant_r, grant_nxt;
  logic       out_valid_r, out_valid_nxt;

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    cmd           = '0;
    st_nxt        = st_r;
    status_nxt    = status_r;
    grant_nxt     = grant_r;
    out_valid_nxt = out_valid_r && !out_tready;
    case (st_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_last) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.ld = 1'b1;
          st_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        grant_nxt = 1'b0;
        if (!sts.pool_ok) begin
          status_nxt = ipba_pkg::ST_INVALID;
          st_nxt     = S_FIN;
        end else if (sts.is_release) begin
          if (sts.oor) begin
            status_nxt = ipba_pkg::ST_OK;
            st_nxt     = S_FIN;
          end else begin
            st_nxt = S_R_RD;
          end
        end else if (sts.drained) begin
          status_nxt = ipba_pkg::ST_DRAINED;
          st_nxt     = S_FIN;
        end else begin
          cmd.gs_rd = 1'b1;
          st_nxt    = S_GS_CHK;
        end
      end
      S_GS_CHK: begin
        if (!sts.gchunk_full) begin
          cmd.g_found = 1'b1;
          st_nxt      = S_WS_RD;
        end else if (sts.gchunk_last) begin
          status_nxt = ipba_pkg::ST_DRAINED;
          st_nxt     = S_FIN;
        end else begin
          cmd.gs_rd = 1'b1;
        end
      end
      S_WS_RD: begin
        cmd.w_rd = 1'b1;
        st_nxt   = S_WS_CHK;
      end
      S_WS_CHK: begin
        if (!sts.rd_full) begin
          cmd.latch = 1'b1;
          st_nxt    = S_A_WR;
        end else if (sts.chk_end) begin
          status_nxt = ipba_pkg::ST_DRAINED;
          st_nxt     = S_FIN;
        end else begin
          cmd.w_rd = 1'b1;
        end
      end
      S_A_WR: begin
        cmd.a_wr   = 1'b1;
        grant_nxt  = 1'b1;
        status_nxt = ipba_pkg::ST_OK;
        if (!sts.new_full)    st_nxt = S_FIN;
        else if (sts.cur_end) st_nxt = S_G_RD;
        else                  st_nxt = S_RS_RD;
      end
      // rest of the group after the word just filled
      S_RS_RD: begin
        cmd.w_rd = 1'b1;
        st_nxt   = S_RS_CHK;
      end
      S_RS_CHK: begin
        if (!sts.rd_full)     st_nxt = S_FIN;
        else if (sts.chk_end) st_nxt = S_G_RD;
        else                  cmd.w_rd = 1'b1;
      end
      S_G_RD: begin
        cmd.g_rd = 1'b1;
        st_nxt   = S_G_WR;
      end
      S_G_WR: begin
        if (sts.is_release) cmd.g_clr = 1'b1;
        else                cmd.g_set = 1'b1;
        status_nxt = ipba_pkg::ST_OK;
        st_nxt     = S_FIN;
      end
      S_R_RD: begin
        cmd.r_rd = 1'b1;
        st_nxt   = S_R_CHK;
      end
      S_R_CHK: begin
        status_nxt = ipba_pkg::ST_OK;
        if (!sts.rel_hit) begin
          st_nxt = S_FIN;
        end else begin
          cmd.latch = 1'b1;
          st_nxt    = S_R_WR;
        end
      end
      S_R_WR: begin
        cmd.r_wr = 1'b1;
        st_nxt   = S_G_RD;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.res_ld     = 1'b1;
          cmd.res_status = status_r;
          cmd.res_grant  = grant_r;
          out_valid_nxt  = 1'b1;
          st_nxt         = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLEAR;
      status_r    <= ipba_pkg::ST_OK;
      grant_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      status_r    <= status_nxt;
      grant_r     <= grant_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### sv/ipba_dpath.sv
// Datapath: config registers, used-bit RAM, group-full RAM, counters and result register.
module ipba_dpath #(
  parameter int POOL_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [0:0]          cfg_addr,
  input  logic [31:0]         cfg_wdata,
  input  logic                in_op,
  input  logic [31:0]         in_addr,
  input  ipba_pkg::ipba_cmd_t cmd,
  output ipba_pkg::ipba_sts_t sts,
  output logic [1:0]          out_status,
  output logic [31:0]         out_addr
);

  localparam int WW        = POOL_BITS - 6;              // word index width
  localparam int WORDS     = 2 ** WW;
  localparam int NGRP      = 2 ** (POOL_BITS - 12);
  localparam int CW        = (POOL_BITS > 18) ? POOL_BITS - 18 : 1;
  localparam int NCH       = (POOL_BITS > 18) ? 2 ** (POOL_BITS - 18) : 1;
  localparam int GDEPTH    = 2 ** CW;
  localparam int CNTW      = POOL_BITS + 1;
  localparam logic [63:0] GMASK =
    (POOL_BITS >= 18) ? 64'hFFFF_FFFF_FFFF_FFFF : ((64'd1 << NGRP) - 64'd1);
  localparam logic [CNTW-1:0] POOL_SIZE_C = CNTW'(1) << POOL_BITS;

  logic [31:0]     pool_network_r;
  logic [5:0]      prefix_r;
  logic [CNTW-1:0] count_r;
  logic [WW-1:0]   clr_cnt_r;

  logic [63:0]     used_mem [WORDS];
  logic [63:0]     grp_mem  [GDEPTH];

  logic [63:0]     rdata_r;
  logic [WW-1:0]   chk_w_r;
  logic [63:0]     gdata_r;
  logic [CW-1:0]   gchk_r;
  logic [CW-1:0]   gptr_r;
  logic [WW-1:0]   ptr_r;
  logic            op_r;
  logic            oor_r;
  logic [WW-1:0]   cur_w_r;
  logic [5:0]      b_r;
  logic [63:0]     cur_word_r;
  logic [31:0]     gaddr_r;
  logic [1:0]      out_status_r;
  logic [31:0]     out_addr_r;

  function automatic logic [CW-1:0] chunk_of(input logic [WW-1:0] w);
    logic [WW-1:0] s;
    s = w >> 12;
    return s[CW-1:0];
  endfunction

  function automatic logic [5:0] gbit_of(input logic [WW-1:0] w);
    logic [WW-1:0] s;
    s = w >> 6;
    return s[5:0];
  endfunction

  // pool checks
  logic [5:0]    hb;
  logic [31:0]   host_mask;
  logic [CNTW:0] cnt3;
  logic [CNTW:0] lim_pow;
  logic          pool_ok;
  logic          drained;

  assign hb        = 6'd32 - prefix_r;
  assign host_mask = ~(32'hFFFF_FFFF << hb);
  assign pool_ok   = (prefix_r <= ipba_pkg::MAX_PREFIX) &&
                     ((pool_network_r & host_mask) == 32'd0);
  assign cnt3      = {1'b0, count_r} + (CNTW + 1)'(ipba_pkg::RESERVED_COUNT);
  assign lim_pow   = (CNTW + 1)'(1) << hb;
  // limit is min(2^hb - 3, pool size); 2^hb beyond CNTW bits never reached
  assign drained   = (count_r >= POOL_SIZE_C) ||
                     ((hb <= 6'(CNTW)) && (cnt3 >= lim_pow));

  logic [31:0] idx;
  logic [5:0]  cur_lz;
  logic [63:0] set_word;
  logic [63:0] clr_word;
  logic [63:0] gview;
  logic [5:0]  glz;
  logic [31:0] gbase;

  assign idx      = in_addr - pool_network_r - 32'd2;
  assign cur_lz   = ipba_pkg::lowest_zero(cur_word_r);
  assign set_word = cur_word_r | (64'd1 << cur_lz);
  assign clr_word = cur_word_r & ~(64'd1 << b_r);
  // groups that do not exist read as full
  assign gview    = gdata_r | ~GMASK;
  assign glz      = ipba_pkg::lowest_zero(gview);
  assign gbase    = 32'({gchk_r, glz}) << 6;

  always_comb begin
    sts             = '0;
    sts.clr_last    = (clr_cnt_r == {WW{1'b1}});
    sts.pool_ok     = pool_ok;
    sts.drained     = drained;
    sts.is_release  = (op_r == ipba_pkg::OP_RELEASE);
    sts.oor         = oor_r;
    sts.rd_full     = (rdata_r == ipba_pkg::WORD_ALL);
    sts.chk_end     = (chk_w_r[5:0] == 6'd63);
    sts.rel_hit     = rdata_r[b_r];
    sts.gchunk_full = (gview == ipba_pkg::WORD_ALL);
    sts.gchunk_last = (gchk_r == CW'(NCH - 1));
    sts.new_full    = (set_word == ipba_pkg::WORD_ALL);
    sts.cur_end     = (cur_w_r[5:0] == 6'd63);
  end

  // config and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_network_r <= 32'd0;
      prefix_r       <= ipba_pkg::PREFIX_RESET;
      count_r        <= '0;
      clr_cnt_r      <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          ipba_pkg::CFG_POOL_NETWORK:  pool_network_r <= cfg_wdata;
          ipba_pkg::CFG_PREFIX_LENGTH: prefix_r       <= cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (cmd.clr_step) clr_cnt_r <= clr_cnt_r + WW'(1);
      if (cmd.a_wr) count_r <= count_r + CNTW'(1);
      else if (cmd.r_wr && (count_r != '0)) count_r <= count_r - CNTW'(1);
    end
  end

  // used-bit RAM, one read and one write port
  logic [WW-1:0] w_raddr;
  assign w_raddr = cmd.r_rd ? cur_w_r : ptr_r;

  always_ff @(posedge clk) begin
    if (cmd.clr_step)  used_mem[clr_cnt_r] <= 64'd0;
    else if (cmd.a_wr) used_mem[cur_w_r]   <= set_word;
    else if (cmd.r_wr) used_mem[cur_w_r]   <= clr_word;
    if (cmd.w_rd || cmd.r_rd) begin
      rdata_r <= used_mem[w_raddr];
      chk_w_r <= w_raddr;
    end
  end

  // group-full RAM, 64 group bits per entry
  logic [CW-1:0] g_raddr;
  logic [CW-1:0] g_waddr;
  assign g_raddr = cmd.gs_rd ? gptr_r : chunk_of(cur_w_r);
  assign g_waddr = chunk_of(cur_w_r);

  always_ff @(posedge clk) begin
    if (cmd.clr_step && ((clr_cnt_r >> CW) == '0))
      grp_mem[clr_cnt_r[CW-1:0]] <= 64'd0;
    else if (cmd.g_set)
      grp_mem[g_waddr] <= gdata_r | (64'd1 << gbit_of(cur_w_r));
    else if (cmd.g_clr)
      grp_mem[g_waddr] <= gdata_r & ~(64'd1 << gbit_of(cur_w_r));
    if (cmd.gs_rd || cmd.g_rd) begin
      gdata_r <= grp_mem[g_raddr];
      gchk_r  <= g_raddr;
    end
  end

  // item, scan pointers and result
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      op_r    <= in_op;
      oor_r   <= (idx[31:POOL_BITS] != '0);
      cur_w_r <= idx[POOL_BITS-1:6];
      b_r     <= idx[5:0];
      gptr_r  <= '0;
    end
    if (cmd.gs_rd) gptr_r <= gptr_r + CW'(1);
    if (cmd.g_found)   ptr_r <= gbase[WW-1:0];
    else if (cmd.a_wr) ptr_r <= cur_w_r + WW'(1);
    else if (cmd.w_rd) ptr_r <= ptr_r + WW'(1);
    if (cmd.latch) begin
      cur_word_r <= rdata_r;
      cur_w_r    <= chk_w_r;
    end
    if (cmd.a_wr)
      gaddr_r <= pool_network_r + 32'd2 + 32'({cur_w_r, cur_lz});
    if (cmd.res_ld) begin
      out_status_r <= cmd.res_status;
      out_addr_r   <= cmd.res_grant ? gaddr_r : 32'd0;
    end
  end

  assign out_status = out_status_r;
  assign out_addr   = out_addr_r;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= POOL_SIZE_C)
    else $error("used count above pool size");

  a_clear_alone: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_step |-> !(cmd.a_wr || cmd.r_wr || cmd.ld || cmd.g_set || cmd.g_clr))
    else $error("store update during clearing pass");

  a_alloc_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.a_wr |-> (cur_word_r != ipba_pkg::WORD_ALL) && (op_r == ipba_pkg::OP_ALLOC))
    else $error("allocation into a full word");

  a_release_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.r_wr |-> !oor_r && (count_r != '0) && cur_word_r[b_r])
    else $error("release of an entry that is not held");
`endif

endmodule
